// ===== rtl/tick_event_divider_with_waits_macros.svh =====
// ----------------------------------------------------------------------------
// Tick event divider with waits: assertion macros
// Shared concurrent assertion forms; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef TICK_EVENT_DIVIDER_WITH_WAITS_MACROS_SVH
`define TICK_EVENT_DIVIDER_WITH_WAITS_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define TEDW_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tedw: assertion failed");

// next-cycle implication
`define TEDW_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tedw: assertion failed");

`else

`define TEDW_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define TEDW_ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/tedw_pkg.sv =====
// ----------------------------------------------------------------------------
// Tick event divider with waits: package
// Item types, command codes, register map and configuration struct.
// ----------------------------------------------------------------------------
`default_nettype none

package tedw_pkg;

   // command codes carried in an input item
   typedef enum logic [2:0] {
      OP_TICK            = 3'd0,
      OP_SERVICE         = 3'd1,
      OP_LOAD_TICK_WAIT  = 3'd2,
      OP_LOAD_SECOND_WAIT = 3'd3,
      OP_SET_RESET       = 3'd4,
      OP_CLEAR_RESET     = 3'd5
   } opcode_type;

   // register indexes (byte address is 4 * index)
   localparam int unsigned CSR_ADDR_W = 5;
   localparam logic [2:0] REG_TICKS_PER_SECOND  = 3'd0;
   localparam logic [2:0] REG_SECONDS_PER_LONG  = 3'd1;
   localparam logic [2:0] REG_IMMEDIATE_TICK    = 3'd2;
   localparam logic [2:0] REG_IMMEDIATE_SECOND  = 3'd3;
   localparam logic [2:0] REG_IMMEDIATE_LONG    = 3'd4;

   // register reset values
   localparam logic [7:0] TICKS_PER_SECOND_RST  = 8'd10;
   localparam logic [7:0] SECONDS_PER_LONG_RST  = 8'd10;
   localparam logic       IMMEDIATE_TICK_RST    = 1'b1;
   localparam logic       IMMEDIATE_SECOND_RST  = 1'b0;
   localparam logic       IMMEDIATE_LONG_RST    = 1'b0;

   // pending flag bit positions
   localparam int unsigned PEND_TICK   = 0;
   localparam int unsigned PEND_SECOND = 1;
   localparam int unsigned PEND_LONG   = 2;

   typedef struct packed {
      logic [2:0] opcode;
      logic [7:0] wait_amount;
   } req_item_type;

   typedef struct packed {
      logic       watchdog_kick;
      logic       run_tick_handler;
      logic       run_second_handler;
      logic       run_long_handler;
      logic       tick_pending;
      logic       second_pending;
      logic       long_pending;
      logic [7:0] tick_wait_left;
      logic [7:0] second_wait_left;
      logic       reset_requested;
   } rsp_item_type;

   // configuration handed from the register file to the step logic
   typedef struct packed {
      logic [7:0] ticks_per_second;
      logic [7:0] seconds_per_long_event;
      logic       immediate_tick_event;
      logic       immediate_second_event;
      logic       immediate_long_event;
   } cfg_type;

endpackage : tedw_pkg

`default_nettype wire

// ===== rtl/tedw_csr.sv =====
// ----------------------------------------------------------------------------
// Tick event divider with waits: register file
// APB-style configuration registers; writes and reads complete with no wait.
// ----------------------------------------------------------------------------
`default_nettype none

module tedw_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [tedw_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [31:0]                       csr_pwdata,
   output logic      [31:0]                       csr_prdata,
   output logic                                   csr_pready,
   output tedw_pkg::cfg_type                      cfg
);
   import tedw_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [2:0] reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:2];

   // write decode; unmapped indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_TICKS_PER_SECOND: cfg_in.ticks_per_second       = csr_pwdata[7:0];
            REG_SECONDS_PER_LONG: cfg_in.seconds_per_long_event = csr_pwdata[7:0];
            REG_IMMEDIATE_TICK:   cfg_in.immediate_tick_event   = csr_pwdata[0];
            REG_IMMEDIATE_SECOND: cfg_in.immediate_second_event = csr_pwdata[0];
            REG_IMMEDIATE_LONG:   cfg_in.immediate_long_event   = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ticks_per_second       <= TICKS_PER_SECOND_RST;
         cfg_ff.seconds_per_long_event <= SECONDS_PER_LONG_RST;
         cfg_ff.immediate_tick_event   <= IMMEDIATE_TICK_RST;
         cfg_ff.immediate_second_event <= IMMEDIATE_SECOND_RST;
         cfg_ff.immediate_long_event   <= IMMEDIATE_LONG_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read mux
   always_comb begin
      unique case (reg_idx)
         REG_TICKS_PER_SECOND: csr_prdata = {24'd0, cfg_ff.ticks_per_second};
         REG_SECONDS_PER_LONG: csr_prdata = {24'd0, cfg_ff.seconds_per_long_event};
         REG_IMMEDIATE_TICK:   csr_prdata = {31'd0, cfg_ff.immediate_tick_event};
         REG_IMMEDIATE_SECOND: csr_prdata = {31'd0, cfg_ff.immediate_second_event};
         REG_IMMEDIATE_LONG:   csr_prdata = {31'd0, cfg_ff.immediate_long_event};
         default:              csr_prdata = 32'd0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule : tedw_csr

`default_nettype wire

// ===== rtl/tedw_step.sv =====
// ----------------------------------------------------------------------------
// Tick event divider with waits: step logic
// Divider, wait and flag state; computes one result per advanced item.
// ----------------------------------------------------------------------------
`default_nettype none

`include "tick_event_divider_with_waits_macros.svh"

module tedw_step (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  tedw_pkg::cfg_type           cfg,
   input  wire logic                   advance,
   input  tedw_pkg::req_item_type      item,
   output tedw_pkg::rsp_item_type      rsp
);
   import tedw_pkg::*;

   logic [7:0] tick_div_ff, tick_div_in;
   logic [7:0] sec_div_ff,  sec_div_in;
   logic [7:0] tick_wait_ff, tick_wait_in;
   logic [7:0] sec_wait_ff,  sec_wait_in;
   logic [2:0] pend_ff, pend_in;
   logic       reset_flag_ff, reset_flag_in;

   logic [7:0] tick_div_inc;
   logic [7:0] sec_div_inc;
   logic [7:0] tick_wait_dec;
   logic [7:0] sec_wait_dec;
   logic       kick, run_t, run_s, run_l;

   // saturating countdowns and wrapping divider increments
   assign tick_div_inc  = tick_div_ff + 8'd1;
   assign sec_div_inc   = sec_div_ff + 8'd1;
   assign tick_wait_dec = (tick_wait_ff != 8'd0) ? tick_wait_ff - 8'd1 : 8'd0;
   assign sec_wait_dec  = (sec_wait_ff != 8'd0) ? sec_wait_ff - 8'd1 : 8'd0;

   // next state and pulses for the item at the input register
   always_comb begin
      tick_div_in   = tick_div_ff;
      sec_div_in    = sec_div_ff;
      tick_wait_in  = tick_wait_ff;
      sec_wait_in   = sec_wait_ff;
      pend_in       = pend_ff;
      reset_flag_in = reset_flag_ff;
      kick  = 1'b0;
      run_t = 1'b0;
      run_s = 1'b0;
      run_l = 1'b0;
      unique case (item.opcode)
         OP_TICK: begin
            tick_div_in = tick_div_inc;
            if (tick_div_inc >= cfg.ticks_per_second) begin
               tick_div_in = 8'd0;
               if (cfg.immediate_second_event) begin
                  sec_wait_in = sec_wait_dec;
                  run_s       = 1'b1;
               end else begin
                  pend_in[PEND_SECOND] = 1'b1;
               end
               sec_div_in = sec_div_inc;
               if (sec_div_inc >= cfg.seconds_per_long_event) begin
                  sec_div_in = 8'd0;
                  if (cfg.immediate_long_event) begin
                     run_l = 1'b1;
                  end else begin
                     pend_in[PEND_LONG] = 1'b1;
                  end
               end
            end
            tick_wait_in = tick_wait_dec;
            kick         = !reset_flag_ff;
            if (cfg.immediate_tick_event) begin
               run_t = 1'b1;
            end else begin
               pend_in[PEND_TICK] = 1'b1;
            end
         end
         OP_SERVICE: begin
            run_t = pend_ff[PEND_TICK];
            run_l = pend_ff[PEND_LONG];
            if (pend_ff[PEND_SECOND]) begin
               sec_wait_in = sec_wait_dec;
               run_s       = 1'b1;
            end
            pend_in = 3'b000;
         end
         OP_LOAD_TICK_WAIT:   tick_wait_in  = item.wait_amount;
         OP_LOAD_SECOND_WAIT: sec_wait_in   = item.wait_amount;
         OP_SET_RESET:        reset_flag_in = 1'b1;
         OP_CLEAR_RESET:      reset_flag_in = 1'b0;
         default: ;
      endcase
   end

   // state commits only when the item moves on to the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_div_ff   <= 8'd0;
         sec_div_ff    <= 8'd0;
         tick_wait_ff  <= 8'd0;
         sec_wait_ff   <= 8'd0;
         pend_ff       <= 3'b000;
         reset_flag_ff <= 1'b0;
      end else if (advance) begin
         tick_div_ff   <= tick_div_in;
         sec_div_ff    <= sec_div_in;
         tick_wait_ff  <= tick_wait_in;
         sec_wait_ff   <= sec_wait_in;
         pend_ff       <= pend_in;
         reset_flag_ff <= reset_flag_in;
      end
   end

   // result fields
   always_comb begin
      rsp.watchdog_kick      = kick;
      rsp.run_tick_handler   = run_t;
      rsp.run_second_handler = run_s;
      rsp.run_long_handler   = run_l;
      rsp.tick_pending       = pend_in[PEND_TICK];
      rsp.second_pending     = pend_in[PEND_SECOND];
      rsp.long_pending       = pend_in[PEND_LONG];
      rsp.tick_wait_left     = tick_wait_in;
      rsp.second_wait_left   = sec_wait_in;
      rsp.reset_requested    = reset_flag_in;
   end

   `TEDW_ASSERT_NXT(a_service_clears, clock, reset, advance && item.opcode == OP_SERVICE, pend_ff == 3'b000)
   `TEDW_ASSERT_NXT(a_tick_wait_no_rise, clock, reset, advance && item.opcode != OP_LOAD_TICK_WAIT, tick_wait_ff <= $past(tick_wait_ff))
   `TEDW_ASSERT_NXT(a_set_reset_flag, clock, reset, advance && item.opcode == OP_SET_RESET, reset_flag_ff)
   `TEDW_ASSERT_NXT(a_hold_when_idle, clock, reset, !advance, $stable(pend_ff) && $stable(sec_wait_ff))

endmodule : tedw_step

`default_nettype wire

// ===== rtl/tick_event_divider_with_waits.sv =====
// ----------------------------------------------------------------------------
// Tick event divider with waits: top level
// Input register, step logic and result register, plus the register file.
// ----------------------------------------------------------------------------
//
//   channel   direction   payload          handshake
//   req_      in          req_item_type    req_valid / req_stall
//   rsp_      out         rsp_item_type    rsp_valid / rsp_stall
//   csr_      in/out      32-bit regs      APB-style, pready tied high
//
// One item per cycle sustained while rsp_stall is low; rsp_valid rises once the
// item has passed the input register and the step logic into the result register.
// Reset is synchronous; it clears the valid bits, counters and flags and loads the register reset values.
// A stalled result holds the result register; the input register then fills
// and req_stall rises in the same cycle as the result stays blocked.
// ----------------------------------------------------------------------------
`default_nettype none

`include "tick_event_divider_with_waits_macros.svh"

module tick_event_divider_with_waits (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  tedw_pkg::req_item_type                 req_item,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output tedw_pkg::rsp_item_type                 rsp_item,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [tedw_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [31:0]                       csr_pwdata,
   output logic      [31:0]                       csr_prdata,
   output logic                                   csr_pready
);
   import tedw_pkg::*;

   cfg_type      cfg;
   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff;
   logic         out_valid_ff, out_valid_in;
   rsp_item_type out_item_ff;
   rsp_item_type step_rsp;
   logic         out_load;
   logic         advance;
   logic         req_take;

   tedw_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   tedw_step u_step (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .advance (advance),
      .item    (in_item_ff),
      .rsp     (step_rsp)
   );

   // flow control: result register frees when empty or taken
   assign out_load  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_load;
   assign req_stall = in_valid_ff && !out_load;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? 1'b1 : (out_load ? 1'b0 : out_valid_ff);

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= req_item;
      end
      if (advance) begin
         out_item_ff <= step_rsp;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

   `TEDW_ASSERT_IMP(a_stall_only_when_full, clock, reset, req_stall, in_valid_ff && out_valid_ff && rsp_stall)
   `TEDW_ASSERT_NXT(a_advance_gives_result, clock, reset, advance, rsp_valid)
   `TEDW_ASSERT_NXT(a_take_fills_input, clock, reset, req_take, in_valid_ff)

endmodule : tick_event_divider_with_waits

`default_nettype wire

// ===== bench/tick_event_divider_with_waits_tb.sv =====
// ----------------------------------------------------------------------------
// Tick event divider with waits: testbench
// Sends tick, service, wait-load and reset-flag commands under several
// divider and mode settings. The sender works in bursts and the receiver
// stalls. A command-level predictor of the dividers, waits and pending
// flags checks every result field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tick_event_divider_with_waits_tb;
   import tedw_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 200000;
   localparam int unsigned REPORT_LIMIT = 10;
   localparam int unsigned NUM_PHASES   = 10;

   // opcodes outside the defined set; the block must ignore them
   localparam logic [2:0] OP_SPARE_6 = 3'd6;
   localparam logic [2:0] OP_SPARE_7 = 3'd7;

   typedef enum int unsigned {
      STALL_NONE,
      STALL_LIGHT,
      STALL_PATTERN,
      STALL_HEAVY
   } stall_mode_type;

   // DUT signals
   logic         clock;
   logic         reset       = 1'b1;
   logic         req_valid   = 1'b0;
   logic         req_stall;
   req_item_type req_item    = '0;
   logic         rsp_valid;
   logic         rsp_stall   = 1'b0;
   rsp_item_type rsp_item;
   logic         csr_psel    = 1'b0;
   logic         csr_penable = 1'b0;
   logic         csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr  = '0;
   logic [31:0]  csr_pwdata  = '0;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   // predictor state and configuration copy
   cfg_type      cfg_model;
   logic [7:0]   tick_div_cnt;
   logic [7:0]   sec_div_cnt;
   logic [7:0]   tick_wait_cnt;
   logic [7:0]   sec_wait_cnt;
   logic [2:0]   pend_flags;
   logic         reset_req;
   rsp_item_type expected_rsp[$];

   // traffic shaping
   bit             gaps_on     = 1'b0;
   int unsigned    burst_left  = 0;
   stall_mode_type stall_style = STALL_NONE;
   int unsigned    stall_phase = 0;

   // bookkeeping
   int unsigned cycle_count     = 0;
   int unsigned items_sent      = 0;
   int unsigned results_checked = 0;
   int unsigned mismatch_count  = 0;
   int unsigned tick_runs       = 0;
   int unsigned second_runs     = 0;
   int unsigned long_runs       = 0;
   int unsigned kicks_seen      = 0;

   tick_event_divider_with_waits u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_item    (req_item),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_item    (rsp_item),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_rsp.size());
      $display("tick_event_divider_with_waits_tb NOT OK");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------

   // wait countdown that holds at zero
   function automatic logic [7:0] count_down(input logic [7:0] v);
      return (v == 8'd0) ? 8'd0 : v - 8'd1;
   endfunction

   function automatic void predictor_reset();
      cfg_model.ticks_per_second       = TICKS_PER_SECOND_RST;
      cfg_model.seconds_per_long_event = SECONDS_PER_LONG_RST;
      cfg_model.immediate_tick_event   = IMMEDIATE_TICK_RST;
      cfg_model.immediate_second_event = IMMEDIATE_SECOND_RST;
      cfg_model.immediate_long_event   = IMMEDIATE_LONG_RST;
      tick_div_cnt  = '0;
      sec_div_cnt   = '0;
      tick_wait_cnt = '0;
      sec_wait_cnt  = '0;
      pend_flags    = '0;
      reset_req     = 1'b0;
   endfunction

   // advance the predicted state by one command and return its result
   function automatic rsp_item_type predict_command(input req_item_type cmd);
      rsp_item_type r;
      r = '0;
      case (cmd.opcode)
         OP_TICK: begin
            tick_div_cnt = tick_div_cnt + 8'd1;
            if (tick_div_cnt >= cfg_model.ticks_per_second) begin
               tick_div_cnt = '0;
               if (cfg_model.immediate_second_event) begin
                  sec_wait_cnt = count_down(sec_wait_cnt);
                  r.run_second_handler = 1'b1;
               end else begin
                  pend_flags[PEND_SECOND] = 1'b1;
               end
               sec_div_cnt = sec_div_cnt + 8'd1;
               if (sec_div_cnt >= cfg_model.seconds_per_long_event) begin
                  sec_div_cnt = '0;
                  if (cfg_model.immediate_long_event) r.run_long_handler = 1'b1;
                  else pend_flags[PEND_LONG] = 1'b1;
               end
            end
            tick_wait_cnt   = count_down(tick_wait_cnt);
            r.watchdog_kick = !reset_req;
            if (cfg_model.immediate_tick_event) r.run_tick_handler = 1'b1;
            else pend_flags[PEND_TICK] = 1'b1;
         end
         OP_SERVICE: begin
            // pending flags are served whatever the mode registers say now
            r.run_tick_handler = pend_flags[PEND_TICK];
            if (pend_flags[PEND_SECOND]) begin
               sec_wait_cnt = count_down(sec_wait_cnt);
               r.run_second_handler = 1'b1;
            end
            r.run_long_handler = pend_flags[PEND_LONG];
            pend_flags = '0;
         end
         OP_LOAD_TICK_WAIT:   tick_wait_cnt = cmd.wait_amount;
         OP_LOAD_SECOND_WAIT: sec_wait_cnt  = cmd.wait_amount;
         OP_SET_RESET:        reset_req     = 1'b1;
         OP_CLEAR_RESET:      reset_req     = 1'b0;
         default: ;
      endcase
      r.tick_pending     = pend_flags[PEND_TICK];
      r.second_pending   = pend_flags[PEND_SECOND];
      r.long_pending     = pend_flags[PEND_LONG];
      r.tick_wait_left   = tick_wait_cnt;
      r.second_wait_left = sec_wait_cnt;
      r.reset_requested  = reset_req;
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Result checking
   // ------------------------------------------------------------------------

   task automatic compare_field(input string field_name, input logic [7:0] want,
                                input logic [7:0] got);
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT)
            $display("result %0d: %s expected %0d, got %0d",
                     results_checked, field_name, want, got);
      end
   endtask

   // single-bit fields
   task automatic compare_bit(input string field_name, input logic want,
                              input logic got);
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT)
            $display("result %0d: %s expected %0b, got %0b",
                     results_checked, field_name, want, got);
      end
   endtask

   task automatic check_result(input rsp_item_type got);
      rsp_item_type want;
      if (expected_rsp.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT)
            $display("unexpected result %p with no command outstanding", got);
      end else begin
         want = expected_rsp.pop_front();
         compare_bit("watchdog_kick",      want.watchdog_kick,      got.watchdog_kick);
         compare_bit("run_tick_handler",   want.run_tick_handler,   got.run_tick_handler);
         compare_bit("run_second_handler", want.run_second_handler, got.run_second_handler);
         compare_bit("run_long_handler",   want.run_long_handler,   got.run_long_handler);
         compare_bit("tick_pending",       want.tick_pending,       got.tick_pending);
         compare_bit("second_pending",     want.second_pending,     got.second_pending);
         compare_bit("long_pending",       want.long_pending,       got.long_pending);
         compare_field("tick_wait_left",   want.tick_wait_left,     got.tick_wait_left);
         compare_field("second_wait_left", want.second_wait_left,   got.second_wait_left);
         compare_bit("reset_requested",    want.reset_requested,    got.reset_requested);
         results_checked++;
         tick_runs   += 32'(want.run_tick_handler);
         second_runs += 32'(want.run_second_handler);
         long_runs   += 32'(want.run_long_handler);
         kicks_seen  += 32'(want.watchdog_kick);
      end
   endtask

   // outputs are sampled mid-cycle, away from the driving edge
   always @(negedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) check_result(rsp_item);
   end

   // receiver back-pressure
   always @(posedge clock) begin
      stall_phase <= stall_phase + 1;
      case (stall_style)
         STALL_LIGHT:   rsp_stall <= ($urandom_range(0, 99) < 30);
         STALL_PATTERN: rsp_stall <= ((stall_phase % 7) < 3);
         STALL_HEAVY:   rsp_stall <= ($urandom_range(0, 99) < 75);
         default:       rsp_stall <= 1'b0;
      endcase
   end

   // ------------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------------

   // one item on the request channel; called and returns at a rising edge
   task automatic send_item(input req_item_type cmd);
      bit taken;
      int unsigned gap;
      if (gaps_on && burst_left == 0) begin
         gap        = $urandom_range(1, 6);
         burst_left = $urandom_range(1, 24);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      if (burst_left > 0) burst_left--;
      req_item  <= cmd;
      req_valid <= 1'b1;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = !req_stall;
         if (taken) begin
            expected_rsp.push_back(predict_command(cmd));
            items_sent++;
         end
         @(posedge clock);
      end
   endtask

   function automatic req_item_type make_cmd(input logic [2:0] op, input logic [7:0] amount);
      req_item_type c;
      c.opcode      = op;
      c.wait_amount = amount;
      return c;
   endfunction

   // mostly ticks and services; loads favor small counts so waits run out
   function automatic req_item_type random_command();
      int unsigned pick;
      logic [2:0]  op;
      logic [7:0]  amount;
      pick = $urandom_range(0, 99);
      if (pick < 48)      op = OP_TICK;
      else if (pick < 70) op = OP_SERVICE;
      else if (pick < 78) op = OP_LOAD_TICK_WAIT;
      else if (pick < 86) op = OP_LOAD_SECOND_WAIT;
      else if (pick < 91) op = OP_SET_RESET;
      else if (pick < 96) op = OP_CLEAR_RESET;
      else if (pick < 98) op = OP_SPARE_6;
      else                op = OP_SPARE_7;
      if ($urandom_range(0, 3) == 0) amount = 8'($urandom_range(0, 255));
      else amount = 8'($urandom_range(0, 12));
      return make_cmd(op, amount);
   endfunction

   // drain: stop sending and let every outstanding result arrive
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   // APB-style register write: setup cycle, access cycle, then idle with psel low
   task automatic csr_write(input logic [2:0] index, input logic [31:0] value);
      bit rdy;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      rdy = 1'b0;
      while (!rdy) begin
         @(negedge clock);
         rdy = csr_pready;
         @(posedge clock);
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      // upper bits beyond each register's width are dropped
      case (index)
         REG_TICKS_PER_SECOND: cfg_model.ticks_per_second       = value[7:0];
         REG_SECONDS_PER_LONG: cfg_model.seconds_per_long_event = value[7:0];
         REG_IMMEDIATE_TICK:   cfg_model.immediate_tick_event   = value[0];
         REG_IMMEDIATE_SECOND: cfg_model.immediate_second_event = value[0];
         REG_IMMEDIATE_LONG:   cfg_model.immediate_long_event   = value[0];
         default: ;
      endcase
   endtask

   // all five registers, with random junk above the used bits half the time
   task automatic configure(input logic [7:0] tps, input logic [7:0] spl,
                            input logic imm_t, input logic imm_s, input logic imm_l);
      logic [31:0] junk;
      junk = $urandom();
      if ($urandom_range(0, 1)) junk = '0;
      csr_write(REG_TICKS_PER_SECOND, {junk[31:8], tps});
      csr_write(REG_SECONDS_PER_LONG, {junk[31:8], spl});
      csr_write(REG_IMMEDIATE_TICK,   {junk[31:1], imm_t});
      csr_write(REG_IMMEDIATE_SECOND, {junk[31:1], imm_s});
      csr_write(REG_IMMEDIATE_LONG,   {junk[31:1], imm_l});
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   task automatic test_directed_cases();
      gaps_on     = 1'b1;
      stall_style = STALL_LIGHT;

      // reset settings: wait extremes, reset flag, spare opcodes, empty service
      send_item(make_cmd(OP_LOAD_TICK_WAIT, 8'd255));
      send_item(make_cmd(OP_LOAD_SECOND_WAIT, 8'd0));
      send_item(make_cmd(OP_TICK, 8'd0));
      send_item(make_cmd(OP_TICK, 8'd255));
      send_item(make_cmd(OP_SET_RESET, 8'd0));
      send_item(make_cmd(OP_TICK, 8'd0));
      send_item(make_cmd(OP_CLEAR_RESET, 8'd0));
      send_item(make_cmd(OP_TICK, 8'd0));
      send_item(make_cmd(OP_SPARE_6, 8'd255));
      send_item(make_cmd(OP_SPARE_7, 8'd170));
      send_item(make_cmd(OP_SERVICE, 8'd0));

      // divider now above the new register value: next tick fires at once
      wait_idle();
      configure(8'd2, 8'd1, 1'b0, 1'b0, 1'b0);
      send_item(make_cmd(OP_LOAD_SECOND_WAIT, 8'd2));
      send_item(make_cmd(OP_TICK, 8'd0));

      // switch to immediate with flags still pending; service must clear them
      wait_idle();
      configure(8'd2, 8'd1, 1'b1, 1'b1, 1'b1);
      send_item(make_cmd(OP_SERVICE, 8'd0));
      send_item(make_cmd(OP_TICK, 8'd0));
      send_item(make_cmd(OP_TICK, 8'd0));
      send_item(make_cmd(OP_TICK, 8'd0));
      send_item(make_cmd(OP_TICK, 8'd0));

      // zero divider values, the first written with a high bit set
      wait_idle();
      csr_write(REG_TICKS_PER_SECOND, 32'h0000_0100);
      csr_write(REG_SECONDS_PER_LONG, 32'h0000_0000);
      send_item(make_cmd(OP_TICK, 8'd0));
      send_item(make_cmd(OP_LOAD_TICK_WAIT, 8'd0));
      send_item(make_cmd(OP_TICK, 8'd0));
   endtask

   task automatic test_random_phases();
      int unsigned phase;
      int unsigned count;
      for (phase = 0; phase < NUM_PHASES; phase++) begin
         wait_idle();
         case (phase)
            0: configure(8'd1, 8'd1, 1'b1, 1'b1, 1'b1);
            1: configure(8'd3, 8'd2, 1'b0, 1'b0, 1'b0);
            2: configure(8'd255, 8'd255, 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            3: configure(8'd0, 8'd0, 1'b0, 1'b1, 1'b0);
            4: configure(8'd2, 8'd5, 1'b1, 1'b0, 1'b1);
            default: configure(8'($urandom_range(1, 6)), 8'($urandom_range(1, 4)),
                               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                               1'($urandom_range(0, 1)));
         endcase
         gaps_on     = (phase % 3) != 0;
         stall_style = stall_mode_type'(phase % 4);
         count       = (phase == 2) ? 60 : 125;
         repeat (count) send_item(random_command());
      end
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------
   initial begin
      predictor_reset();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_cases();
      test_random_phases();
      wait_idle();

      $display("covered %0d commands over %0d random settings plus directed cases, %0d checked",
               items_sent, NUM_PHASES, results_checked);
      $display("handler runs tick %0d second %0d long %0d, watchdog kicks %0d, mismatches %0d",
               tick_runs, second_runs, long_runs, kicks_seen, mismatch_count);
      if (mismatch_count == 0) begin
         $display("tick_event_divider_with_waits_tb OK");
      end else begin
         $display("tick_event_divider_with_waits_tb NOT OK");
      end
      $finish;
   end

endmodule
